// File: rtl/dlc_pkg.sv
`default_nettype none
package dlc_pkg;
  localparam int LINE_CYCLES_DEF = 228;
  localparam int Y_OFFSET_DEF = 16;
  localparam logic [31:0] HALTED = 32'hffffffff;
  localparam logic [31:0] END_MARKER = 32'hfffffffe;
  localparam logic [31:0] FRAME_START = 32'd40;

  localparam logic [2:0] FUNC_EXEC = 3'd0;
  localparam logic [2:0] FUNC_JMP1 = 3'd1;
  localparam logic [2:0] FUNC_JMP2 = 3'd2;
  localparam logic [2:0] FUNC_DMA = 3'd3;
  localparam logic [2:0] FUNC_EOF = 3'd4;

  localparam logic [1:0] REG_DANGER = 2'd0;
  localparam logic [1:0] REG_LIST1 = 2'd1;
  localparam logic [1:0] REG_LIST2 = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] instruction;
    logic [31:0] current_cycle;
    logic [8:0]  raster_y;
    logic [7:0]  raster_x;
    logic [3:0]  display_mode;
    logic        blitter_busy;
    logic [31:0] blitter_end_cycle;
    logic        dma_enable;
  } item_t;

  typedef struct packed {
    logic [31:0] next_event_cycle;
    logic [20:0] program_pointer;
    logic        write_valid;
    logic [8:0]  write_register;
    logic [15:0] write_data;
  } result_t;

  function automatic logic [4:0] move_cost(input logic [3:0] mode);
    logic [4:0] c;
    unique case (mode)
      4'd5: c = 5'd5;
      4'd6: c = 5'd6;
      4'd11: c = 5'd8;
      4'd12: c = 5'd16;
      default: c = 5'd4;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// File: rtl/dlc_queue.sv
`default_nettype none
module dlc_queue import dlc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);
  item_t mem [2];
  logic [1:0] count;
  logic wr_ptr, rd_ptr;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/dlc_exec.sv
`default_nettype none
module dlc_exec import dlc_pkg::*; #(
  parameter int LINE_CYCLES = LINE_CYCLES_DEF,
  parameter int Y_OFFSET = Y_OFFSET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        danger_en,
  input  wire logic [20:0] list1,
  input  wire logic [20:0] list2,
  input  wire logic        in_valid,
  input  wire item_t       in_item,
  output logic             in_pop,
  output logic             valid,
  input  wire logic        stall,
  output result_t          res
);
  localparam logic [31:0] LC = 32'(LINE_CYCLES);
  localparam logic [31:0] YO = 32'(Y_OFFSET);
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_FUTURE = 2'd1;
  localparam logic [1:0] KIND_PASSED = 2'd2;

  // stage 1 registers: decoded transaction and chosen beam line
  logic s1_valid;
  logic [1:0] s1_kind;
  logic [31:0] s1_cycle;  // final cycle when direct, else the current cycle
  logic [8:0] s1_line;
  logic [7:0] s1_xterm;
  logic [20:0] s1_ptr;
  logic s1_wv;
  logic [8:0] s1_wr;
  logic [15:0] s1_wd;

  logic [20:0] pointer;
  logic [31:0] next_cycle, susp;
  logic dma_on;

  logic adv;
  assign adv = !valid || !stall;
  assign in_pop = in_valid && adv;

  // stage 2: beam cycle from the registered line
  logic [31:0] prod, calc, live_next;
  always_comb begin
    prod = 32'(s1_line) * LC;
    unique case (s1_kind)
      KIND_FUTURE: calc = prod + YO + 32'(s1_xterm) + 32'd4;
      KIND_PASSED: begin
        calc = 32'(s1_xterm) + prod + 32'd4;
        if (calc <= s1_cycle) calc = s1_cycle + 32'd4;
      end
      default: calc = s1_cycle;
    endcase
  end

  // a beam cycle still in stage 2 is the current next cycle for decode
  assign live_next = (s1_valid && s1_kind != KIND_DIRECT) ? calc : next_cycle;

  // decode
  logic [15:0] w1, w2, d;
  logic [7:0] wy, wx, my, mx, ivm, ihm;
  logic [8:0] reg_a;
  logic [31:0] cyc4, bend4;
  logic [20:0] p4;
  logic passed;
  logic [20:0] np;
  logic [31:0] nc, ns;
  logic nd, wv;
  logic [1:0] kind;
  logic [8:0] line;
  logic [7:0] xt;
  always_comb begin
    w1 = in_item.instruction[31:16];
    w2 = in_item.instruction[15:0];
    d = w2 | 16'h8000;
    wy = w1[15:8];
    wx = w1[7:0] & 8'hfe;
    my = in_item.raster_y[7:0] & d[15:8];
    mx = in_item.raster_x & d[7:0];
    ivm = ~d[15:8];
    ihm = ~d[7:0] & 8'hfe;
    reg_a = w1[8:0] & 9'h1fe;
    cyc4 = in_item.current_cycle + 32'd4;
    bend4 = in_item.blitter_end_cycle + 32'd4;
    p4 = pointer + 21'd4;
    np = pointer; nc = live_next; ns = susp; nd = dma_on; wv = 1'b0;
    kind = KIND_DIRECT; line = '0; xt = wx; passed = 1'b0;
    unique case (in_item.func)
      FUNC_EXEC: begin
        np = p4;
        if (in_item.instruction == END_MARKER) begin
          nc = HALTED;
        end else if (!w1[0]) begin
          if (reg_a >= 9'h80 || (reg_a >= 9'h40 && danger_en)) begin
            nc = in_item.current_cycle + 32'(move_cost(in_item.display_mode));
            wv = 1'b1;
          end else begin
            nc = HALTED;
          end
        end else if (!w2[15] && in_item.blitter_busy) begin
          np = pointer;
          nc = (bend4 <= in_item.current_cycle) ? cyc4 : bend4;
        end else if (w2[0]) begin
          if (my > wy || (my == wy && mx >= wx)) np = pointer + 21'd8;
          nc = cyc4;
        end else begin
          passed = (my > wy) || (my == wy && mx >= wx);
          if (passed) begin
            if (in_item.raster_y != 9'd255 || wy > 8'h40) begin
              nc = cyc4;
            end else begin
              kind = KIND_PASSED;
              nc = in_item.current_cycle;
              line = {1'b1, ivm | wy};
              xt = wx | (in_item.raster_x & ihm);
            end
          end else begin
            kind = KIND_FUTURE;
            nc = in_item.current_cycle;
            line = {in_item.raster_y[8], (in_item.raster_y[7:0] & ivm) | wy};
            xt = ((my == wy) && (ihm < in_item.raster_x)) ?
                 ((ihm & in_item.raster_x) | wx) : wx;
          end
        end
      end
      FUNC_JMP1, FUNC_JMP2: begin
        np = (in_item.func == FUNC_JMP1) ? list1 : list2;
        if (dma_on) nc = cyc4;
      end
      FUNC_DMA: begin
        if (dma_on) begin
          if (!in_item.dma_enable) begin
            ns = live_next; nc = HALTED; nd = 1'b0;
          end
        end else if (in_item.dma_enable) begin
          nc = (susp != HALTED && susp <= in_item.current_cycle) ? cyc4 : susp;
          nd = 1'b1;
        end
      end
      FUNC_EOF: begin
        np = list1; ns = FRAME_START;
        if (dma_on) nc = FRAME_START;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0; s1_kind <= KIND_DIRECT; valid <= 1'b0;
      pointer <= '0; next_cycle <= HALTED; susp <= HALTED; dma_on <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_pop;
      valid <= s1_valid;
      if (s1_valid) begin
        res.next_event_cycle <= calc;
        res.program_pointer <= s1_ptr;
        res.write_valid <= s1_wv;
        res.write_register <= s1_wv ? s1_wr : 9'd0;
        res.write_data <= s1_wv ? s1_wd : 16'd0;
      end
      if (in_pop && kind == KIND_DIRECT) next_cycle <= nc;
      else if (s1_valid && s1_kind != KIND_DIRECT) next_cycle <= calc;
      if (in_pop) begin
        pointer <= np;
        susp <= ns;
        dma_on <= nd;
        s1_kind <= kind;
        s1_cycle <= nc;
        s1_line <= line;
        s1_xterm <= xt;
        s1_ptr <= np;
        s1_wv <= wv;
        s1_wr <= reg_a;
        s1_wd <= w2;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/display_list_coprocessor.sv
// channel | valid          | stall          | payload
// input   | in_valid       | in_stall (out) | func .. dma_enable
// result  | out_valid      | out_stall (in) | next_event_cycle .. write_data
// One transaction per cycle sustained while out_stall is low; each passes
// queue write, decode and the beam-cycle multiply into the output register.
// The single LINE_CYCLES multiplier sets the clock.
// Synchronous active-high rst clears queue, pipeline valids and state.
// A stalled result holds; the queue absorbs two items before in_stall rises.
`default_nettype none
module display_list_coprocessor import dlc_pkg::*; #(
  parameter int LINE_CYCLES = LINE_CYCLES_DEF,
  parameter int Y_OFFSET = Y_OFFSET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] current_cycle,
  input  wire logic [8:0]  raster_y,
  input  wire logic [7:0]  raster_x,
  input  wire logic [3:0]  display_mode,
  input  wire logic        blitter_busy,
  input  wire logic [31:0] blitter_end_cycle,
  input  wire logic        dma_enable,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      next_event_cycle,
  output logic [20:0]      program_pointer,
  output logic             write_valid,
  output logic [8:0]       write_register,
  output logic [15:0]      write_data
);
  logic danger_en;
  logic [20:0] list1, list2;
  always_ff @(posedge clk) begin
    if (rst) begin
      danger_en <= 1'b0; list1 <= '0; list2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DANGER: danger_en <= cfg_data[0];
        REG_LIST1: list1 <= cfg_data & 21'h1ffffe;
        REG_LIST2: list2 <= cfg_data & 21'h1ffffe;
        default: ;
      endcase
    end
  end

  item_t it, head;
  logic full, empty, pop;
  result_t res;
  assign it = '{func, instruction, current_cycle, raster_y, raster_x,
                display_mode, blitter_busy, blitter_end_cycle, dma_enable};
  assign in_stall = full;

  // front: hold accepted transactions until the back end takes them
  dlc_queue u_q (.clk, .rst, .push(in_valid && !full), .push_item(it),
    .full, .pop, .head, .empty);

  dlc_exec #(.LINE_CYCLES(LINE_CYCLES), .Y_OFFSET(Y_OFFSET)) u_x (
    .clk, .rst, .danger_en, .list1, .list2, .in_valid(!empty), .in_item(head),
    .in_pop(pop), .valid(out_valid), .stall(out_stall), .res);

  assign next_event_cycle = res.next_event_cycle;
  assign program_pointer = res.program_pointer;
  assign write_valid = res.write_valid;
  assign write_register = res.write_register;
  assign write_data = res.write_data;
endmodule
`default_nettype wire

// File: rtl/dlc_checker.sv
`default_nettype none
module dlc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic write_valid,
  input wire logic [8:0] write_register,
  input wire logic [20:0] program_pointer
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !program_pointer[0]) else $error("odd pointer");
  a_reg: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> write_register >= 9'h40) else $error("bad write");
endmodule
bind display_list_coprocessor dlc_checker u_chk (.clk, .rst, .out_valid,
  .out_stall, .write_valid, .write_register, .program_pointer);
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dlc_pkg::*;

  localparam int LINE_CYC = 228;
  localparam int Y_OFS = 16;
  localparam logic [20:0] PTR_MASK = 21'h1ffffe;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // Configuration port
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DANGER;
  logic [20:0] cfg_data = '0;

  // Input channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       drv_item = '0;

  // Result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     got;

  display_list_coprocessor i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(drv_item.func), .instruction(drv_item.instruction),
    .current_cycle(drv_item.current_cycle), .raster_y(drv_item.raster_y),
    .raster_x(drv_item.raster_x), .display_mode(drv_item.display_mode),
    .blitter_busy(drv_item.blitter_busy),
    .blitter_end_cycle(drv_item.blitter_end_cycle),
    .dma_enable(drv_item.dma_enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_event_cycle(got.next_event_cycle), .program_pointer(got.program_pointer),
    .write_valid(got.write_valid), .write_register(got.write_register),
    .write_data(got.write_data)
  );

  // Predicted coprocessor state and registers
  logic [20:0] pc_q;
  logic [31:0] next_ev_q;
  logic [31:0] parked_wait_q;
  logic        dma_on_q;
  logic        danger_q;
  logic [20:0] list1_q, list2_q;

  item_t   pending_items[$];
  result_t expected_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  idle_free = 1'b0;      // disable random idling on both sides
  bit  sender_hold = 1'b0;    // sender paused by the sequencer
  int  hold_off_cycles = 0;   // long receiver hold-off request

  function automatic logic [4:0] mode_cost(input logic [3:0] m);
    case (m)
      4'd5: return 5'd5;
      4'd6: return 5'd6;
      4'd11: return 5'd8;
      4'd12: return 5'd16;
      default: return 5'd4;
    endcase
  endfunction

  // Wait position already passed, with the line-255 correction.
  function automatic logic [31:0] beam_passed(input logic [31:0] d, input logic [31:0] wy,
      input logic [31:0] wx, input logic [8:0] ry, input logic [7:0] rx,
      input logic [31:0] cyc);
    logic [31:0] inv, line, c;
    if (ry != 9'd255 || wy > 32'h40) return cyc + 32'd4;
    inv = ~d;
    line = 32'h100 | (((inv >> 8) & 32'hff) | wy);
    c = (wx | ({24'd0, rx} & inv & 32'hfe)) + line * LINE_CYC + 32'd4;
    if (c <= cyc) c = cyc + 32'd4;
    return c;
  endfunction

  function automatic logic [31:0] beam_future(input logic [31:0] d, input logic [31:0] wy,
      input logic [31:0] wx, input logic [8:0] ry, input logic [7:0] rx, input bit same_line);
    logic [31:0] inv, ivm, ihm, line, base, rxw;
    inv = ~d;
    ivm = (inv >> 8) & 32'hff;
    ihm = inv & 32'hfe;
    rxw = {24'd0, rx};
    line = ({23'd0, ry} & 32'h100) | ((({23'd0, ry} & 32'hff) & ivm) | wy);
    base = line * LINE_CYC + Y_OFS;
    if (same_line && ihm < rxw) return base + ((ihm & rxw) | wx) + 32'd4;
    return base + wx + 32'd4;
  endfunction

  function automatic void decode_instruction(input item_t it, inout result_t r);
    logic [31:0] w1, w2, d, wy, wx, my, mx, cyc;
    logic [8:0] rg;
    cyc = it.current_cycle;
    pc_q = (pc_q + 21'd4) & PTR_MASK;
    if (it.instruction == END_MARKER) begin
      next_ev_q = HALTED;
      return;
    end
    w1 = it.instruction >> 16;
    w2 = it.instruction & 32'hffff;
    if (w1[0] == 1'b0) begin
      rg = w1[8:0] & 9'h1fe;
      if (rg >= 9'h80 || (rg >= 9'h40 && danger_q)) begin
        next_ev_q = cyc + 32'(mode_cost(it.display_mode));
        r.write_valid = 1'b1;
        r.write_register = rg;
        r.write_data = w2[15:0];
      end else begin
        next_ev_q = HALTED;
      end
      return;
    end
    w1 = w1 & 32'hfffe;
    if (w2[15] == 1'b0 && it.blitter_busy) begin
      pc_q = (pc_q - 21'd4) & PTR_MASK;
      next_ev_q = (it.blitter_end_cycle + 32'd4 <= cyc) ? cyc + 32'd4
                                                         : it.blitter_end_cycle + 32'd4;
      return;
    end
    d = w2 | 32'h8000;
    wy = (w1 >> 8) & 32'hff;
    wx = w1 & 32'hfe;
    my = {24'd0, it.raster_y[7:0]} & ((d >> 8) & 32'hff);
    mx = {24'd0, it.raster_x} & d & 32'hff;
    if (w2[0] == 1'b0) begin
      if (my > wy) next_ev_q = beam_passed(d, wy, wx, it.raster_y, it.raster_x, cyc);
      else if (my < wy) next_ev_q = beam_future(d, wy, wx, it.raster_y, it.raster_x, 1'b0);
      else if (mx < wx) next_ev_q = beam_future(d, wy, wx, it.raster_y, it.raster_x, 1'b1);
      else next_ev_q = beam_passed(d, wy, wx, it.raster_y, it.raster_x, cyc);
    end else begin
      if (my > wy || (my == wy && mx >= (w1 & 32'hff))) pc_q = (pc_q + 21'd4) & PTR_MASK;
      next_ev_q = cyc + 32'd4;
    end
  endfunction

  function automatic result_t predict_step(input item_t it);
    result_t r;
    logic [31:0] cyc;
    r = '0;
    cyc = it.current_cycle;
    case (it.func)
      FUNC_EXEC: decode_instruction(it, r);
      FUNC_JMP1, FUNC_JMP2: begin
        pc_q = (it.func == FUNC_JMP1) ? list1_q : list2_q;
        if (dma_on_q) next_ev_q = cyc + 32'd4;
      end
      FUNC_DMA: begin
        if (dma_on_q) begin
          if (!it.dma_enable) begin
            parked_wait_q = next_ev_q;
            next_ev_q = HALTED;
            dma_on_q = 1'b0;
          end
        end else if (it.dma_enable) begin
          if (parked_wait_q != HALTED && parked_wait_q <= cyc) next_ev_q = cyc + 32'd4;
          else next_ev_q = parked_wait_q;
          dma_on_q = 1'b1;
        end
      end
      FUNC_EOF: begin
        pc_q = list1_q;
        parked_wait_q = FRAME_START;
        if (dma_on_q) next_ev_q = FRAME_START;
      end
      default: ;
    endcase
    r.next_event_cycle = next_ev_q;
    r.program_pointer = pc_q & PTR_MASK;
    return r;
  endfunction

  // Driver: advance to the next pending transaction once the current one is taken.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !sender_hold &&
            (idle_free || $urandom_range(99) >= 21)) begin
          drv_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict at acceptance so the state follows the block's order.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) expected_results.push_back(predict_step(drv_item));
  end

  // Receiver stall: random, or held for a long stretch on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_off_cycles != 0 && hold_left == 0) begin
      hold_left <= hold_off_cycles;
      hold_off_cycles <= 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      out_stall <= !idle_free && ($urandom_range(99) < 21);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", got);
      end else begin
        e = expected_results.pop_front();
        if (got !== e) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p got %p", e, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** display_list_coprocessor: FAILED **");
      $finish;
    end
  end

  function automatic item_t blank_item(input logic [2:0] f);
    item_t it;
    it = '0;
    it.func = f;
    it.current_cycle = $urandom();
    it.raster_y = 9'($urandom_range(511));
    it.raster_x = 8'($urandom_range(255));
    it.display_mode = 4'($urandom_range(15));
    it.blitter_end_cycle = $urandom();
    return it;
  endfunction

  // Random item, biased toward execute with realistic moves, waits and skips.
  function automatic item_t random_item();
    item_t it;
    int k;
    logic [15:0] w1, w2;
    k = $urandom_range(99);
    if (k < 6) it = blank_item(FUNC_JMP1);
    else if (k < 11) it = blank_item(FUNC_JMP2);
    else if (k < 19) it = blank_item(FUNC_DMA);
    else if (k < 23) it = blank_item(FUNC_EOF);
    else if (k < 25) it = blank_item(3'($urandom_range(7, 5)));
    else it = blank_item(FUNC_EXEC);
    it.dma_enable = 1'($urandom_range(1));
    it.blitter_busy = ($urandom_range(3) == 0);
    if ($urandom_range(3) == 0) it.raster_y = 9'd255;
    if ($urandom_range(3) == 0)
      it.blitter_end_cycle = it.current_cycle + 32'($urandom_range(40)) - 32'd20;
    if ($urandom_range(9) == 0)
      it.current_cycle = 32'hffffffff - 32'($urandom_range(300));
    k = $urandom_range(9);
    w1 = 16'($urandom());
    w2 = 16'($urandom());
    if (k < 4) w1[0] = 1'b0;                              // move
    else if (k < 8) begin
      w1[0] = 1'b1;
      w2[15] = 1'($urandom_range(1));
      if ($urandom_range(2) == 0) w1[15:8] = 8'($urandom_range(64));
      if ($urandom_range(2) == 0) w1[15:8] = it.raster_y[7:0];
      if ($urandom_range(2) == 0) w2[14:8] = 7'h7f;
    end
    it.instruction = {w1, w2};
    if (k == 9) it.instruction = $urandom();
    if (k == 8) it.instruction = END_MARKER;
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DANGER: danger_q = val[0];
      REG_LIST1: list1_q = val & PTR_MASK;
      default: list2_q = val & PTR_MASK;
    endcase
  endtask

  // Wait for every queued item and result, then let the pipeline drain.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic directed_items();
    item_t it;
    logic [2:0] f;
    for (int i = 0; i < 8; i++) begin
      f = 3'(i);
      it = blank_item(f);
      it.dma_enable = 1'b1;
      pending_items.push_back(it);
    end
    it = blank_item(FUNC_EXEC);
    it.instruction = END_MARKER;
    pending_items.push_back(it);
    it.instruction = 32'h0020_1234;                        // protected move
    pending_items.push_back(it);
    it.instruction = 32'h0044_ffff;                        // danger range move
    pending_items.push_back(it);
    it.instruction = 32'h01fe_0000;
    it.display_mode = 4'd12;
    pending_items.push_back(it);
    it.instruction = 32'h2001_0000;                        // blitter wait
    it.blitter_busy = 1'b1;
    it.blitter_end_cycle = it.current_cycle + 32'd100;
    pending_items.push_back(it);
    it.blitter_end_cycle = it.current_cycle - 32'd100;
    pending_items.push_back(it);
    it.blitter_busy = 1'b0;
    it.raster_y = 9'd255;                                  // line-255 wrap
    it.raster_x = 8'hff;
    it.instruction = 32'h1001_fffe;
    pending_items.push_back(it);
    it.current_cycle = 32'hffffffff;
    pending_items.push_back(it);
    it.raster_y = 9'h1ff;
    it.raster_x = 8'd0;
    it.instruction = 32'hff01_fffe;                        // wait already passed
    pending_items.push_back(it);
    it.raster_y = 9'd0;
    it.instruction = 32'h0001_ff00;                        // same line
    pending_items.push_back(it);
    it.instruction = 32'h0001_ffff;                        // skip
    pending_items.push_back(it);
    it.instruction = 32'hffff_ffff;
    pending_items.push_back(it);
    it.instruction = 32'h0000_0000;
    pending_items.push_back(it);
  endtask

  initial begin
    pc_q = '0; next_ev_q = HALTED; parked_wait_q = HALTED; dma_on_q = 1'b0;
    danger_q = 1'b0; list1_q = '0; list2_q = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_LIST1, 21'h1fffff);
    write_reg(REG_LIST2, 21'h000000);
    directed_items();
    drain();

    // Settings sweep: random list locations, with extremes in phases 1 and 2.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_DANGER, 21'(phase[0]));
      write_reg(REG_LIST1, (phase == 1) ? 21'h0 : 21'($urandom()));
      write_reg(REG_LIST2, (phase == 2) ? 21'h1fffff : 21'($urandom()));
      idle_free = (phase == 3);
      for (int i = 0; i < 150; i++) pending_items.push_back(random_item());
      if (phase == 4) begin
        // Hold the receiver off so the block fills and stalls its input.
        hold_off_cycles = 200;
      end
      if (phase == 2) begin
        // Pause the sender until every result is in, then go on.
        while (pending_items.size() > 75) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("** display_list_coprocessor: PASSED **");
    end else begin
      $display("** display_list_coprocessor: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/dlc_pkg.sv
rtl/dlc_queue.sv
rtl/dlc_exec.sv
rtl/display_list_coprocessor.sv
rtl/dlc_checker.sv
sim/tb_top.sv
